// File: hw/rtl/egss_pkg.sv
// Shared widths, register codes, reset values and result type of the speech segmenter.
package egss_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SQ_W       = 2 * SAMPLE_W;
	localparam int SUM_W      = 39;
	localparam int THR_W      = 31;
	localparam int MS_W       = 16;
	localparam int TIME_W     = 17;
	localparam int LEN_W      = 21;
	localparam int CNT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam int DEF_MAX_FRAME_SAMPLES = 256;

	localparam int RATE_HZ        = 16000;
	localparam int MS_PER_S       = 1000;
	localparam int SAMPLES_PER_MS = RATE_HZ / MS_PER_S;
	localparam int MS_SHIFT       = $clog2(SAMPLES_PER_MS);

	localparam logic [THR_W-1:0] RST_THRESHOLD_SQ  = THR_W'(122500);
	localparam logic [MS_W-1:0]  RST_SPEECH_START  = MS_W'(100);
	localparam logic [MS_W-1:0]  RST_SILENCE_LIMIT = MS_W'(700);
	localparam logic [MS_W-1:0]  RST_MIN_SPEECH    = MS_W'(1500);
	localparam logic [MS_W-1:0]  RST_MAX_SEGMENT   = MS_W'(5000);
	localparam logic [CNT_W-1:0] RST_MAX_EVENTS    = CNT_W'(0);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD_SQ  = 3'd0,
		CFG_SPEECH_START  = 3'd1,
		CFG_SILENCE_LIMIT = 3'd2,
		CFG_MIN_SPEECH    = 3'd3,
		CFG_MAX_SEGMENT   = 3'd4,
		CFG_MAX_EVENTS    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic             frame_done;
		logic             frame_speech;
		logic             collecting_now;
		logic             segment_end;
		logic             segment_accepted;
		logic [LEN_W-1:0] segment_samples;
		logic             finished;
	} res_t;

endpackage

// File: hw/rtl/egss_if.sv
// Stream interfaces of the speech segmenter: samples in, results out, register writes.
interface egss_in_if import egss_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       frame_last;

	modport source (output valid, output sample, output frame_last, input ready);
	modport sink   (input valid, input sample, input frame_last, output ready);
endinterface

interface egss_out_if import egss_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             frame_done;
	logic             frame_speech;
	logic             collecting_now;
	logic             segment_end;
	logic             segment_accepted;
	logic [LEN_W-1:0] segment_samples;
	logic             finished;

	modport source (output valid, output frame_done, output frame_speech,
		output collecting_now, output segment_end, output segment_accepted,
		output segment_samples, output finished, input ready);
	modport sink   (input valid, input frame_done, input frame_speech,
		input collecting_now, input segment_end, input segment_accepted,
		input segment_samples, input finished, output ready);
endinterface

interface egss_cfg_if import egss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/energy_gated_speech_segmenter.sv
// Energy-gated speech segmenter: frame energy gate and segment tracker, top level.
//
//  channel  | dir | payload                                          | request means
//  ---------+-----+--------------------------------------------------+---------------------------
//  samples  | in  | sample[15:0] signed, frame_last                  | one audio sample
//  results  | out | frame_done, frame_speech, collecting_now,        | one result per sample
//           |     | segment_end, segment_accepted, segment_samples,  |
//           |     | finished                                         |
//  cfg      | in  | index[2:0], data[30:0]                           | one register write
//
//  Flow: one request per clock while results.ready keeps the pipe moving; a sample's result
//    is valid once it has passed four register stages: input reg, square/threshold multiply,
//    energy add+compare, segment update into the output reg.
//  Reset: arst_n clears all control state and loads register defaults; no clearing pass.
//  Stalls: each stage advances into a free or draining slot, so bubbles collapse and new
//    samples are taken while a finished result waits on results.ready; four in flight max.
//  cfg is always ready; a write is registered at the edge where cfg.valid is high.
module energy_gated_speech_segmenter import egss_pkg::*; #(
	parameter int MAX_FRAME_SAMPLES = DEF_MAX_FRAME_SAMPLES
) (
	input  logic       clk,
	input  logic       arst_n,
	egss_in_if.sink    samples,
	egss_out_if.source results,
	egss_cfg_if.sink   cfg
);

	// n needs to hold MAX_FRAME_SAMPLES itself; the running count stops one short of it
	localparam int N_W    = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int FCNT_W = $clog2(MAX_FRAME_SAMPLES);
	localparam int THRN_W = THR_W + N_W;
	localparam int CMP_W  = (SUM_W > THRN_W) ? SUM_W : THRN_W;
	localparam int FMS_W  = N_W - MS_SHIFT;

	// ---------------- configuration registers ----------------
	logic [THR_W-1:0] thr_q;
	logic [MS_W-1:0]  start_ms_q;
	logic [MS_W-1:0]  silence_ms_q;
	logic [MS_W-1:0]  min_ms_q;
	logic [MS_W-1:0]  max_seg_ms_q;
	logic [CNT_W-1:0] max_events_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= RST_THRESHOLD_SQ;
			start_ms_q   <= RST_SPEECH_START;
			silence_ms_q <= RST_SILENCE_LIMIT;
			min_ms_q     <= RST_MIN_SPEECH;
			max_seg_ms_q <= RST_MAX_SEGMENT;
			max_events_q <= RST_MAX_EVENTS;
		end else if (cfg.valid) begin
			// indexes past the list fall through to default and are dropped
			unique case (cfg_idx_t'(cfg.index))
				CFG_THRESHOLD_SQ:  thr_q        <= cfg.data[THR_W-1:0];
				CFG_SPEECH_START:  start_ms_q   <= cfg.data[MS_W-1:0];
				CFG_SILENCE_LIMIT: silence_ms_q <= cfg.data[MS_W-1:0];
				CFG_MIN_SPEECH:    min_ms_q     <= cfg.data[MS_W-1:0];
				CFG_MAX_SEGMENT:   max_seg_ms_q <= cfg.data[MS_W-1:0];
				CFG_MAX_EVENTS:    max_events_q <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage enables ----------------
	// A slot loads when it is empty or its occupant moves on this edge.
	logic v_s1, v_s2, v_s3, vo_q;
	logic en1, en2, en3, en_o;

	assign en_o = !vo_q || results.ready;
	assign en3  = !v_s3 || en_o;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;

	assign samples.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1)  v_s1 <= samples.valid;
			if (en2)  v_s2 <= v_s1;
			if (en3)  v_s3 <= v_s2;
			if (en_o) vo_q <= v_s3;
		end
	end

	// ---------------- stage 1: input register, square, threshold * n ----------------
	logic [SAMPLE_W-1:0] raw_s1;
	logic                last_s1;

	always_ff @(posedge clk) begin
		if (en1 && samples.valid) begin
			raw_s1  <= samples.sample;
			last_s1 <= samples.frame_last;
		end
	end

	logic [FCNT_W-1:0]   fcnt_q;
	logic [N_W-1:0]      n_s1;
	logic                close_s1;
	logic [SAMPLE_W-1:0] mag_s1;
	logic [SQ_W-1:0]     sq_s1;
	logic [THRN_W-1:0]   thrn_s1;

	always_comb begin
		n_s1     = N_W'(fcnt_q) + N_W'(1);
		// overlong frame closes itself
		close_s1 = last_s1 || (n_s1 >= N_W'(MAX_FRAME_SAMPLES));
		// two's complement magnitude; -32768 maps to 0x8000
		mag_s1   = raw_s1[SAMPLE_W-1] ? (SAMPLE_W'(0) - raw_s1) : raw_s1;
		sq_s1    = SQ_W'(mag_s1) * SQ_W'(mag_s1);
		thrn_s1  = THRN_W'(thr_q) * THRN_W'(n_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
		end else if (v_s1 && en2) begin
			fcnt_q <= close_s1 ? '0 : FCNT_W'(n_s1);
		end
	end

	logic [SQ_W-1:0]   sq_s2;
	logic [THRN_W-1:0] thrn_s2;
	logic [N_W-1:0]    n_s2;
	logic              close_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			sq_s2    <= sq_s1;
			thrn_s2  <= thrn_s1;
			n_s2     <= n_s1;
			close_s2 <= close_s1;
		end
	end

	// ---------------- stage 2: energy accumulate and gate ----------------
	logic [SUM_W-1:0] psum_q;
	logic [SUM_W-1:0] psum_s2;
	logic             speech_s2;

	always_comb begin
		psum_s2   = psum_q + SUM_W'(sq_s2);
		speech_s2 = CMP_W'(psum_s2) >= CMP_W'(thrn_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
		end else if (v_s2 && en3) begin
			psum_q <= close_s2 ? '0 : psum_s2;
		end
	end

	logic           speech_s3;
	logic           close_s3;
	logic [N_W-1:0] n_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			speech_s3 <= close_s2 && speech_s2;
			close_s3  <= close_s2;
			n_s3      <= n_s2;
		end
	end

	// ---------------- stage 3: segment tracker ----------------
	logic [TIME_W-1:0] speech_t_q;
	logic [TIME_W-1:0] silence_t_q;
	logic [LEN_W-1:0]  pend_q;
	logic [LEN_W-1:0]  seglen_q;
	logic              collecting_q;
	logic [CNT_W-1:0]  evt_q;
	logic              stopped_q;

	logic [TIME_W-1:0] speech_t_d;
	logic [TIME_W-1:0] silence_t_d;
	logic [LEN_W-1:0]  pend_d;
	logic [LEN_W-1:0]  seglen_d;
	logic              collecting_d;
	logic [CNT_W-1:0]  evt_d;
	logic              stopped_d;
	res_t              res_s3;

	always_comb begin
		logic [FMS_W-1:0]         fms;
		logic [TIME_W:0]          st_sum;
		logic [TIME_W-1:0]        st_sat;
		logic [TIME_W:0]          sil_sum;
		logic [TIME_W-1:0]        sil_sat;
		logic [LEN_W:0]           pend_sum;
		logic [LEN_W-1:0]         pend_sat;
		logic [LEN_W:0]           seg_sum;
		logic [LEN_W-1:0]         seg_sat;
		logic [LEN_W-MS_SHIFT-1:0] seg_ms;
		logic [CNT_W-1:0]         evt_inc;
		logic                     seg_close;

		speech_t_d   = speech_t_q;
		silence_t_d  = silence_t_q;
		pend_d       = pend_q;
		seglen_d     = seglen_q;
		collecting_d = collecting_q;
		evt_d        = evt_q;
		stopped_d    = stopped_q;

		// frame time in ms, never below one
		fms = n_s3[N_W-1:MS_SHIFT];
		if (fms == '0) fms = FMS_W'(1);

		st_sum   = {1'b0, speech_t_q} + (TIME_W+1)'(fms);
		st_sat   = st_sum[TIME_W] ? '1 : st_sum[TIME_W-1:0];
		sil_sum  = {1'b0, silence_t_q} + (TIME_W+1)'(fms);
		sil_sat  = sil_sum[TIME_W] ? '1 : sil_sum[TIME_W-1:0];
		pend_sum = {1'b0, pend_q} + (LEN_W+1)'(n_s3);
		pend_sat = pend_sum[LEN_W] ? '1 : pend_sum[LEN_W-1:0];
		seg_sum  = {1'b0, seglen_q} + (LEN_W+1)'(n_s3);
		seg_sat  = seg_sum[LEN_W] ? '1 : seg_sum[LEN_W-1:0];
		seg_ms   = seg_sat[LEN_W-1:MS_SHIFT];
		evt_inc  = (&evt_q) ? evt_q : evt_q + CNT_W'(1);
		seg_close = 1'b0;

		res_s3 = '0;

		if (stopped_q) begin
			// parked: input ignored, state held
			res_s3.finished = 1'b1;
		end else if (!close_s3) begin
			res_s3.collecting_now = collecting_q;
		end else begin
			if (!collecting_q) begin
				if (speech_s3) begin
					pend_d     = pend_sat;
					speech_t_d = st_sat;
					if (st_sat >= TIME_W'(start_ms_q)) begin
						// start frame is not checked for an end
						collecting_d = 1'b1;
						seglen_d     = pend_sat;
						pend_d       = '0;
						silence_t_d  = '0;
					end
				end else begin
					pend_d     = '0;
					speech_t_d = '0;
				end
			end else begin
				seglen_d    = seg_sat;
				silence_t_d = speech_s3 ? '0 : sil_sat;
				seg_close   = (silence_t_d >= TIME_W'(silence_ms_q)) ||
					(seg_ms >= (LEN_W-MS_SHIFT)'(max_seg_ms_q));
				if (seg_close) begin
					res_s3.segment_end     = 1'b1;
					res_s3.segment_samples = seg_sat;
					if (seg_ms >= (LEN_W-MS_SHIFT)'(min_ms_q)) begin
						res_s3.segment_accepted = 1'b1;
						evt_d = evt_inc;
						if ((max_events_q != '0) && (evt_inc >= max_events_q)) begin
							stopped_d = 1'b1;
						end
					end
					seglen_d     = '0;
					pend_d       = '0;
					speech_t_d   = '0;
					silence_t_d  = '0;
					collecting_d = 1'b0;
				end
			end
			res_s3.frame_done     = 1'b1;
			res_s3.frame_speech   = speech_s3;
			res_s3.collecting_now = collecting_d;
			res_s3.finished       = stopped_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speech_t_q   <= '0;
			silence_t_q  <= '0;
			pend_q       <= '0;
			seglen_q     <= '0;
			collecting_q <= 1'b0;
			evt_q        <= '0;
			stopped_q    <= 1'b0;
		end else if (v_s3 && en_o) begin
			speech_t_q   <= speech_t_d;
			silence_t_q  <= silence_t_d;
			pend_q       <= pend_d;
			seglen_q     <= seglen_d;
			collecting_q <= collecting_d;
			evt_q        <= evt_d;
			stopped_q    <= stopped_d;
		end
	end

	// ---------------- output register ----------------
	res_t res_q;

	always_ff @(posedge clk) begin
		if (en_o && v_s3) begin
			res_q <= res_s3;
		end
	end

	assign results.valid            = vo_q;
	assign results.frame_done       = res_q.frame_done;
	assign results.frame_speech     = res_q.frame_speech;
	assign results.collecting_now   = res_q.collecting_now;
	assign results.segment_end      = res_q.segment_end;
	assign results.segment_accepted = res_q.segment_accepted;
	assign results.segment_samples  = res_q.segment_samples;
	assign results.finished         = res_q.finished;

	// ---------------- assertions ----------------
	a_pend_idle_while_collecting: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> (pend_q == '0))
		else $error("pending length not cleared while collecting");

	a_idle_segment_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!collecting_q |-> ((seglen_q == '0) && (silence_t_q == '0)))
		else $error("segment state left over outside a segment");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stop released without reset");

	a_end_closes_collection: assert property (@(posedge clk) disable iff (!arst_n)
		(vo_q && res_q.segment_end) |-> !res_q.collecting_now)
		else $error("segment end reported while still collecting");

endmodule

// File: sim/energy_gated_speech_segmenter_tb.sv
// Self-checking testbench for the energy-gated speech segmenter, with a scoreboard class.
`timescale 1ns / 1ps

module energy_gated_speech_segmenter_tb;
	import egss_pkg::*;

	// Pipeline depth of the block: a sample's result is registered through the input,
	// multiply, energy and output registers.
	localparam int PIPE_DEPTH  = 3;
	// Cycles with no request moving on any channel before the run is declared hung.
	localparam int STALL_LIMIT = 3000;
	// Long receiver hold-off, so the pipeline fills and samples back up.
	localparam int LONG_HOLD   = 300;

	localparam int unsigned TIME_MAX  = (1 << TIME_W) - 1;
	localparam int unsigned LEN_MAX   = (1 << LEN_W) - 1;
	localparam int unsigned COUNT_MAX = (1 << CNT_W) - 1;

	// Indexes beyond the register file; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

	typedef enum int {K_SPEECH, K_SILENT, K_NOISE} frame_kind_t;
	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_EVERY_THIRD, RDY_SPARSE} stall_mode_t;

	// One register setting plus the shape of the audio sent under it.
	typedef struct packed {
		int unsigned thr_sq;
		int unsigned start_ms;
		int unsigned quiet_lim;
		int unsigned min_ms;
		int unsigned max_ms;
		int unsigned cap;
		int          items;
		int          loud_min;   // smallest magnitude of a speech sample
		int          quiet_max;  // largest magnitude of a silent sample
	} phase_t;

	// Scoreboard: mirrors the segmenter state and holds one predicted result per sample.
	class segmenter_score;
		int unsigned thr_sq         = 32'(RST_THRESHOLD_SQ);
		int unsigned start_ms       = 32'(RST_SPEECH_START);
		int unsigned quiet_limit_ms = 32'(RST_SILENCE_LIMIT);
		int unsigned min_ms         = 32'(RST_MIN_SPEECH);
		int unsigned max_ms         = 32'(RST_MAX_SEGMENT);
		int unsigned event_cap      = 32'(RST_MAX_EVENTS);

		logic [SUM_W-1:0] energy_acc = '0;
		int unsigned frame_fill   = 0;
		int unsigned talk_ms      = 0;
		int unsigned quiet_ms     = 0;
		int unsigned lead_in_len  = 0;
		int unsigned seg_len      = 0;
		int unsigned accepted_cnt = 0;
		bit          in_segment   = 0;
		bit          halted       = 0;

		res_t        pending_results[$];
		int unsigned errors  = 0;
		int unsigned checked = 0;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_THRESHOLD_SQ:  thr_sq = 32'(data);
				CFG_SPEECH_START:  start_ms = 32'(data[MS_W-1:0]);
				CFG_SILENCE_LIMIT: quiet_limit_ms = 32'(data[MS_W-1:0]);
				CFG_MIN_SPEECH:    min_ms = 32'(data[MS_W-1:0]);
				CFG_MAX_SEGMENT:   max_ms = 32'(data[MS_W-1:0]);
				CFG_MAX_EVENTS:    event_cap = 32'(data[CNT_W-1:0]);
				default: ;
			endcase
		endfunction

		function int unsigned sat(int unsigned a, int unsigned b, int unsigned lim);
			int unsigned s;
			s = a + b;
			return (s > lim) ? lim : s;
		endfunction

		// Advance the mirror by one accepted sample and queue the result it must produce.
		function void take_sample(logic signed [SAMPLE_W-1:0] smp, logic last);
			logic [SAMPLE_W-1:0] mag;
			int unsigned n, fms, seg_ms;
			bit speech;
			res_t r;
			r = '0;
			if (halted) begin
				r.finished = 1'b1;
				pending_results.push_back(r);
				return;
			end
			// -32768 has magnitude 32768, which still fits 16 unsigned bits
			mag = smp[SAMPLE_W-1] ? SAMPLE_W'(-smp) : smp;
			energy_acc = energy_acc + SUM_W'(mag) * SUM_W'(mag);
			n = frame_fill + 1;
			// frame stays open unless flagged or it hits the hard length cap
			if (!last && n < DEF_MAX_FRAME_SAMPLES) begin
				frame_fill = n;
				r.collecting_now = in_segment;
				pending_results.push_back(r);
				return;
			end
			fms = n * MS_PER_S / RATE_HZ;
			if (fms < 1)
				fms = 1;
			speech = 64'(energy_acc) >= 64'(thr_sq) * 64'(n);
			energy_acc = '0;
			frame_fill = 0;
			if (!in_segment) begin
				if (speech) begin
					lead_in_len = sat(lead_in_len, n, LEN_MAX);
					talk_ms = sat(talk_ms, fms, TIME_MAX);
					if (talk_ms >= start_ms) begin
						// the opening frame is never tested for an end
						in_segment = 1'b1;
						seg_len = lead_in_len;
						lead_in_len = 0;
						quiet_ms = 0;
					end
				end else begin
					lead_in_len = 0;
					talk_ms = 0;
				end
			end else begin
				seg_len = sat(seg_len, n, LEN_MAX);
				quiet_ms = speech ? 0 : sat(quiet_ms, fms, TIME_MAX);
				seg_ms = seg_len * MS_PER_S / RATE_HZ;
				if (quiet_ms >= quiet_limit_ms || seg_ms >= max_ms) begin
					r.segment_end = 1'b1;
					r.segment_samples = LEN_W'(seg_len);
					if (seg_ms >= min_ms) begin
						r.segment_accepted = 1'b1;
						accepted_cnt = sat(accepted_cnt, 1, COUNT_MAX);
						// limit is only looked at when a segment is accepted
						if (event_cap > 0 && accepted_cnt >= event_cap)
							halted = 1'b1;
					end
					seg_len = 0;
					lead_in_len = 0;
					talk_ms = 0;
					quiet_ms = 0;
					in_segment = 1'b0;
				end
			end
			r.frame_done = 1'b1;
			r.frame_speech = speech;
			r.collecting_now = in_segment;
			r.finished = halted;
			pending_results.push_back(r);
		endfunction

		function void report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= 50)
				$display("mismatch on result %0d, %s: got %0d want %0d at %0t",
					checked, what, got, want, $time);
		endfunction

		function void check_result(res_t got);
			res_t want;
			checked++;
			if (pending_results.size() == 0) begin
				report("result with no sample pending", 1, 0);
				return;
			end
			want = pending_results.pop_front();
			if (got.frame_done !== want.frame_done)
				report("frame_done", 32'(got.frame_done), 32'(want.frame_done));
			if (got.frame_speech !== want.frame_speech)
				report("frame_speech", 32'(got.frame_speech), 32'(want.frame_speech));
			if (got.collecting_now !== want.collecting_now)
				report("collecting_now", 32'(got.collecting_now), 32'(want.collecting_now));
			if (got.segment_end !== want.segment_end)
				report("segment_end", 32'(got.segment_end), 32'(want.segment_end));
			if (got.segment_accepted !== want.segment_accepted)
				report("segment_accepted", 32'(got.segment_accepted),
					32'(want.segment_accepted));
			if (got.segment_samples !== want.segment_samples)
				report("segment_samples", 32'(got.segment_samples),
					32'(want.segment_samples));
			if (got.finished !== want.finished)
				report("finished", 32'(got.finished), 32'(want.finished));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	egss_in_if  samples();
	egss_out_if results();
	egss_cfg_if cfg();

	energy_gated_speech_segmenter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg)
	);

	segmenter_score sb;
	int burst_left;   // sample requests left in the current sender burst
	bit hold_req;     // asks the receiver for one long hold-off
	int idle_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Channel drivers. All of them are entered and left at a falling edge;
	// a request is taken at the rising edge where valid and ready are high.
	// ------------------------------------------------------------------

	// Sender works in bursts; between most bursts valid drops for a random gap.
	// Within a burst valid stays high, so back-to-back requests never
	// lower and raise valid in the same step.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic last);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				samples.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			// now and then a long run with no gaps at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 30);
		end
		samples.valid      <= 1'b1;
		samples.sample     <= smp;
		samples.frame_last <= last;
		do @(posedge clk); while (samples.ready !== 1'b1);
		sb.take_sample(smp, last);
		burst_left--;
		@(negedge clk);
	endtask

	// One register write; the caller drops cfg.valid after its last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Load a whole setting. The 16-bit registers get junk in the upper data
	// bits, which the block must mask off; an unmapped index gets a write too.
	task automatic program_regs(input phase_t p);
		write_reg(CFG_THRESHOLD_SQ, CFG_DATA_W'(p.thr_sq));
		write_reg(CFG_SPEECH_START, {15'($urandom), 16'(p.start_ms)});
		write_reg(CFG_SILENCE_LIMIT, {15'($urandom), 16'(p.quiet_lim)});
		write_reg(CFG_MIN_SPEECH, {15'($urandom), 16'(p.min_ms)});
		write_reg(CFG_MAX_SEGMENT, {15'($urandom), 16'(p.max_ms)});
		write_reg(CFG_MAX_EVENTS, {15'($urandom), 16'(p.cap)});
		write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B,
			CFG_DATA_W'($urandom));
		cfg.valid <= 1'b0;
	endtask

	// Stop sending, wait for every predicted result, then let the pipe settle
	// so the next register writes land on an idle block.
	task automatic drain();
		samples.valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 4) @(negedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] make_sample(frame_kind_t kind, phase_t p);
		logic [SAMPLE_W-1:0] mag;
		case (kind)
			K_SPEECH: begin
				if ($urandom_range(0, 31) == 0)
					return 16'sh8000;
				mag = SAMPLE_W'($urandom_range(p.loud_min, 32767));
			end
			K_SILENT: mag = SAMPLE_W'($urandom_range(0, p.quiet_max));
			default:  return SAMPLE_W'($urandom);
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// Well-formed frames in runs of speech and silence, with some noise frames,
	// a few long frames and the odd overlong one that the block must cut at
	// its cap without a frame_last.
	task automatic run_frames(input phase_t p);
		frame_kind_t kind;
		int sent, len, run_left, sel, i;
		sent = 0;
		run_left = 0;
		kind = K_SILENT;
		while (sent < p.items) begin
			if (run_left == 0) begin
				sel = $urandom_range(0, 9);
				if (sel < 5) begin
					kind = K_SPEECH;
					run_left = $urandom_range(1, 8);
				end else if (sel < 9) begin
					kind = K_SILENT;
					run_left = $urandom_range(1, 6);
				end else begin
					kind = K_NOISE;
					run_left = $urandom_range(1, 2);
				end
			end
			run_left--;
			sel = $urandom_range(0, 49);
			if (sel == 0)
				len = $urandom_range(200, 300);
			else if (sel < 8)
				len = $urandom_range(16, 64);
			else
				len = $urandom_range(1, 20);
			for (i = 0; i < len; i++)
				send_sample(make_sample(kind, p), i == len - 1);
			sent += len;
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: ready follows a stall pattern redrawn at random on its own cycle count,
	// except for one long hold-off counted here when hold_req is raised.
	// ------------------------------------------------------------------
	initial begin : drive_ready
		int cyc;
		stall_mode_t mode;
		cyc = 0;
		mode = RDY_ALWAYS;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				results.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (cyc % 48 == 0)
					mode = stall_mode_t'($urandom_range(0, 3));
				cyc++;
				case (mode)
					RDY_ALWAYS:      results.ready <= 1'b1;
					RDY_COIN:        results.ready <= 1'($urandom_range(0, 1));
					RDY_EVERY_THIRD: results.ready <= (cyc % 3) != 0;
					default:         results.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Check every result request against the oldest prediction.
	always @(posedge clk) begin : watch_results
		res_t got;
		if (arst_n && results.valid === 1'b1 && results.ready === 1'b1) begin
			got = {results.frame_done, results.frame_speech, results.collecting_now,
				results.segment_end, results.segment_accepted, results.segment_samples,
				results.finished};
			sb.check_result(got);
		end
	end

	// Hang detector: counts cycles where no request moves on any channel.
	always @(posedge clk) begin
		if (!arst_n || (samples.valid && samples.ready) || (results.valid && results.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		phase_t plan[6];
		phase_t opening;
		int i;
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.sample = '0;
		samples.frame_last = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		burst_left = 0;
		hold_req = 1'b0;
		idle_cycles = 0;
		sb = new();

		// Tiny times so segments open and close within a few frames.
		// Fields: thr_sq, start_ms, quiet_lim, min_ms, max_ms, cap, items, loud_min, quiet_max
		opening = '{1000, 1, 2, 1, 1, 0, 0, 1000, 60};
		plan[0] = '{10000, $urandom_range(1, 3), $urandom_range(2, 4), $urandom_range(2, 5),
			$urandom_range(6, 10), 0, 200, 1000, 60};
		// threshold of one: a frame is silence only when its energy is under its length;
		// every segment is accepted; event limit at its top
		plan[1] = '{1, 1, 1, 0, 2, 65535, 150, 1, 0};
		// everything at the top: no frame can be speech
		plan[2] = '{32'h7FFF_FFFF, 65535, 65535, 65535, 65535, 65535, 40, 1000, 60};
		// zeros: every frame is speech, a segment opens at once and ends on
		// the frame after
		plan[3] = '{0, 0, 0, 1, 0, 0, 60, 1000, 60};
		plan[4] = '{20000, $urandom_range(2, 4), $urandom_range(2, 3), $urandom_range(4, 8),
			$urandom_range(8, 14), 0, 180, 1000, 60};
		// event limit lowered below the count already reached: the block stops
		// on the next accepted segment and then ignores its input
		plan[5] = '{5000, 2, 2, 3, 10, 2, 150, 1000, 60};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Register defaults: one loud and one quiet single-sample frame.
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sd100, 1'b1);
		drain();

		program_regs(opening);
		// Segment opened by one full-scale sample, dropped by silence as too short.
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd0, 1'b1);
		// A 16-sample frame long enough to hit max length at once; its opening
		// frame is skipped, so the next frame ends it and it is accepted.
		for (i = 0; i < 16; i++)
			send_sample((i == 0) ? -16'sd1 : (i == 1) ? 16'sd1
				: (i % 2) ? 16'sd20000 : -16'sd20000, i == 15);
		send_sample(16'sd0, 1'b1);
		drain();

		for (i = 0; i < 6; i++) begin
			program_regs(plan[i]);
			if (i == 0) begin
				// long receiver hold-off while the sender keeps pushing
				hold_req = 1'b1;
				burst_left = 400;
			end
			run_frames(plan[i]);
			drain();
		end

		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
